[src/iee_pkg.sv]
// ============================================================================
// iee_pkg
// Shared types, constants and microcode table of the infix expression
// evaluator.
// ============================================================================
`default_nettype none

package iee_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int PC_WIDTH    = 5;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [PC_WIDTH-1:0]    pc_t;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } chr_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_zero;
  } res_t;

  typedef enum logic [1:0] {
    MULOP_NONE,
    MULOP_MUL,
    MULOP_DIV
  } mulop_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MOVE,
    OP_MUL,
    OP_DIV_START,
    OP_DIV_END,
    OP_SET_MULOP,
    OP_CLOSE_TERM,
    OP_SET_FIN,
    OP_EMIT,
    OP_DIGIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_NOT_OP,
    C_MUL_PEND,
    C_DIV_PEND,
    C_DIV_BUSY,
    C_FIN,
    C_ADDOP,
    C_NOT_LAST,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic is_op;
    logic is_addop;
    logic mul_pend;
    logic div_pend;
    logic fin;
    logic last;
    logic div_busy;
    logic in_valid;
    logic out_full;
  } sts_t;

  localparam pc_t A_WAIT    = 5'd0;
  localparam pc_t A_TESTOP  = 5'd1;
  localparam pc_t A_CN      = 5'd2;
  localparam pc_t A_CN_DIV  = 5'd3;
  localparam pc_t A_MOVE    = 5'd4;
  localparam pc_t A_MUL     = 5'd5;
  localparam pc_t A_DIVS    = 5'd6;
  localparam pc_t A_DIVW    = 5'd7;
  localparam pc_t A_DIVE    = 5'd8;
  localparam pc_t A_AFTER   = 5'd9;
  localparam pc_t A_TESTADD = 5'd10;
  localparam pc_t A_SETMUL  = 5'd11;
  localparam pc_t A_CT      = 5'd12;
  localparam pc_t A_LASTCHK = 5'd13;
  localparam pc_t A_SETFIN  = 5'd14;
  localparam pc_t A_EMIT    = 5'd15;
  localparam pc_t A_RET     = 5'd16;
  localparam pc_t A_DIGIT   = 5'd17;

  function automatic ucode_t ucode_rom(input pc_t addr);
    ucode_t w;
    case (addr)
      A_WAIT:    w = '{op: OP_ACCEPT,     cond: C_NO_IN,    target: A_WAIT};
      A_TESTOP:  w = '{op: OP_NONE,       cond: C_NOT_OP,   target: A_DIGIT};
      A_CN:      w = '{op: OP_NONE,       cond: C_MUL_PEND, target: A_MUL};
      A_CN_DIV:  w = '{op: OP_NONE,       cond: C_DIV_PEND, target: A_DIVS};
      A_MOVE:    w = '{op: OP_MOVE,       cond: C_ALWAYS,   target: A_AFTER};
      A_MUL:     w = '{op: OP_MUL,        cond: C_ALWAYS,   target: A_AFTER};
      A_DIVS:    w = '{op: OP_DIV_START,  cond: C_NEVER,    target: A_WAIT};
      A_DIVW:    w = '{op: OP_NONE,       cond: C_DIV_BUSY, target: A_DIVW};
      A_DIVE:    w = '{op: OP_DIV_END,    cond: C_NEVER,    target: A_WAIT};
      A_AFTER:   w = '{op: OP_NONE,       cond: C_FIN,      target: A_CT};
      A_TESTADD: w = '{op: OP_NONE,       cond: C_ADDOP,    target: A_CT};
      A_SETMUL:  w = '{op: OP_SET_MULOP,  cond: C_ALWAYS,   target: A_LASTCHK};
      A_CT:      w = '{op: OP_CLOSE_TERM, cond: C_FIN,      target: A_EMIT};
      A_LASTCHK: w = '{op: OP_NONE,       cond: C_NOT_LAST, target: A_WAIT};
      A_SETFIN:  w = '{op: OP_SET_FIN,    cond: C_ALWAYS,   target: A_CN};
      A_EMIT:    w = '{op: OP_EMIT,       cond: C_OUT_FULL, target: A_EMIT};
      A_RET:     w = '{op: OP_NONE,       cond: C_ALWAYS,   target: A_WAIT};
      A_DIGIT:   w = '{op: OP_DIGIT,      cond: C_ALWAYS,   target: A_LASTCHK};
      default:   w = '{op: OP_NONE,       cond: C_ALWAYS,   target: A_WAIT};
    endcase
    return w;
  endfunction

  function automatic value_t magnitude(input value_t v);
    return v[VALUE_WIDTH-1] ? (~v + value_t'(1)) : v;
  endfunction

endpackage

`default_nettype wire

[src/infix_expression_evaluator_core.sv]
// ============================================================================
// infix_expression_evaluator_core
// Character-serial evaluator of + - * / expressions with precedence.
// ============================================================================
// Each transaction on the chr channel carries one ASCII character; the
// transaction marked is_last returns one transaction on the res channel with
// the 32-bit wrapped value and a sticky divide-by-zero flag, after which the
// evaluator is ready for the next expression. A microcoded sequencer steps
// through the work for each character, whether a digit, an operator or an
// operator that closes a pending division, which waits on the bit-per-cycle
// divider. The final character adds a second closing pass and the posting
// of the result, and the post holds while the previous result has not been
// taken. A finished result waits in the output register while the next
// character is accepted.
`default_nettype none

module infix_expression_evaluator_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               chr_valid,
  output logic              chr_ready,
  input  iee_pkg::chr_t     chr_data,
  output logic              res_valid,
  input  wire               res_ready,
  output iee_pkg::res_t     res_data
);

  iee_pkg::op_t  op;
  iee_pkg::sts_t sts;

  iee_seq u_seq (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .op  (op)
  );

  iee_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .sts       (sts),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_data  (chr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

[src/iee_div.sv]
// ============================================================================
// iee_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module iee_div (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  iee_pkg::value_t    dividend,
  input  iee_pkg::value_t    divisor,
  output logic               busy,
  output iee_pkg::value_t    quotient
);

  localparam int W  = iee_pkg::VALUE_WIDTH;
  localparam int CW = $clog2(W);

  iee_pkg::value_t rem;
  iee_pkg::value_t quo;
  iee_pkg::value_t dvs;
  logic [CW-1:0]   cnt;
  logic [W:0]      rem_sh;
  logic [W:0]      diff;

  assign rem_sh   = {rem, quo[W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[src/iee_seq.sv]
// ============================================================================
// iee_seq
// Microcode sequencer: step counter, control store and branch test.
// ============================================================================
`default_nettype none

module iee_seq (
  input  wire              clk,
  input  wire              rst,
  input  iee_pkg::sts_t    sts,
  output iee_pkg::op_t     op
);

  iee_pkg::pc_t    pc;
  iee_pkg::pc_t    pc_next;
  iee_pkg::ucode_t cw;
  logic            take;

  always_comb begin
    cw = iee_pkg::ucode_rom(pc);
    case (cw.cond)
      iee_pkg::C_NEVER:    take = 1'b0;
      iee_pkg::C_ALWAYS:   take = 1'b1;
      iee_pkg::C_NO_IN:    take = !sts.in_valid;
      iee_pkg::C_NOT_OP:   take = !sts.is_op;
      iee_pkg::C_MUL_PEND: take = sts.mul_pend;
      iee_pkg::C_DIV_PEND: take = sts.div_pend;
      iee_pkg::C_DIV_BUSY: take = sts.div_busy;
      iee_pkg::C_FIN:      take = sts.fin;
      iee_pkg::C_ADDOP:    take = sts.is_addop;
      iee_pkg::C_NOT_LAST: take = !sts.last;
      iee_pkg::C_OUT_FULL: take = sts.out_full;
      default:             take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + iee_pkg::PC_WIDTH'(1);
    op      = cw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= iee_pkg::A_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

[src/iee_dp.sv]
// ============================================================================
// iee_dp
// Datapath: accumulators, pending operators, multiplier and result register.
// ============================================================================
`default_nettype none

module iee_dp (
  input  wire               clk,
  input  wire               rst,
  input  iee_pkg::op_t      op,
  output iee_pkg::sts_t     sts,
  input  wire               chr_valid,
  output logic              chr_ready,
  input  iee_pkg::chr_t     chr_data,
  output logic              res_valid,
  input  wire               res_ready,
  output iee_pkg::res_t     res_data
);

  localparam int W = iee_pkg::VALUE_WIDTH;

  iee_pkg::value_t sum;
  iee_pkg::value_t term;
  iee_pkg::value_t num;
  logic            addop;
  iee_pkg::mulop_t mulop;
  logic            zdiv;
  logic            fin;
  logic [7:0]      chr;
  logic            last;
  logic            dz;
  logic            dneg;
  iee_pkg::value_t prod;
  iee_pkg::value_t digit;
  iee_pkg::value_t quo;
  logic            div_start;
  logic            div_busy;
  logic            out_full;

  assign prod      = term * num;
  assign digit     = (num << 3) + (num << 1) + W'(chr) - W'(iee_pkg::CHAR_ZERO);
  assign div_start = (op == iee_pkg::OP_DIV_START);
  assign chr_ready = (op == iee_pkg::OP_ACCEPT);
  assign out_full  = res_valid && !res_ready;

  always_comb begin
    sts.is_op    = (chr == iee_pkg::CHAR_PLUS) || (chr == iee_pkg::CHAR_MINUS) ||
                   (chr == iee_pkg::CHAR_STAR) || (chr == iee_pkg::CHAR_SLASH);
    sts.is_addop = (chr == iee_pkg::CHAR_PLUS) || (chr == iee_pkg::CHAR_MINUS);
    sts.mul_pend = (mulop == iee_pkg::MULOP_MUL);
    sts.div_pend = (mulop == iee_pkg::MULOP_DIV);
    sts.fin      = fin;
    sts.last     = last;
    sts.div_busy = div_busy;
    sts.in_valid = chr_valid;
    sts.out_full = out_full;
  end

  iee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (iee_pkg::magnitude(term)),
    .divisor  (iee_pkg::magnitude(num)),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      term      <= '0;
      num       <= '0;
      addop     <= 1'b0;
      mulop     <= iee_pkg::MULOP_NONE;
      zdiv      <= 1'b0;
      fin       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (op != iee_pkg::OP_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (op)
        iee_pkg::OP_ACCEPT: begin
          if (chr_valid) begin
            chr  <= chr_data.char_code;
            last <= chr_data.is_last;
          end
        end
        iee_pkg::OP_MOVE: begin
          term <= num;
          num  <= '0;
        end
        iee_pkg::OP_MUL: begin
          term <= prod;
          num  <= '0;
        end
        iee_pkg::OP_DIV_START: begin
          dz   <= (num == '0);
          dneg <= term[W-1] ^ num[W-1];
          if (num == '0) begin
            zdiv <= 1'b1;
          end
        end
        iee_pkg::OP_DIV_END: begin
          term <= dz ? '0 : (dneg ? (~quo + W'(1)) : quo);
          num  <= '0;
        end
        iee_pkg::OP_SET_MULOP: begin
          mulop <= (chr == iee_pkg::CHAR_STAR) ? iee_pkg::MULOP_MUL : iee_pkg::MULOP_DIV;
        end
        iee_pkg::OP_CLOSE_TERM: begin
          sum   <= addop ? (sum - term) : (sum + term);
          term  <= '0;
          mulop <= iee_pkg::MULOP_NONE;
          addop <= (chr == iee_pkg::CHAR_MINUS);
        end
        iee_pkg::OP_SET_FIN: begin
          fin <= 1'b1;
        end
        iee_pkg::OP_EMIT: begin
          if (!out_full) begin
            res_data.value    <= $signed(sum[31:0]);
            res_data.div_zero <= zdiv;
            res_valid         <= 1'b1;
            sum               <= '0;
            term              <= '0;
            num               <= '0;
            addop             <= 1'b0;
            mulop             <= iee_pkg::MULOP_NONE;
            zdiv              <= 1'b0;
            fin               <= 1'b0;
          end
        end
        iee_pkg::OP_DIGIT: begin
          num <= digit;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
